/* rtl/pgim_pkg.sv */
// pgim_pkg: shared types and constants for the pixel gray/invert/mirror block
// pixel layout, mode and register codes, sequencer states, luma coefficients
// no dependencies
package pgim_pkg;

  localparam int ChanW        = 16;
  localparam int PixW         = 3 * ChanW;
  localparam int MaxRowPixels = 64;
  localparam int ColW         = $clog2(MaxRowPixels);
  localparam int RowWidthW    = 7;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 16;

  // luma weights in Q0.16, rounded to nearest
  localparam int CoefW = 16;
  localparam logic [CoefW-1:0] CoefRed   = 16'd19589;
  localparam logic [CoefW-1:0] CoefGreen = 16'd38470;
  localparam logic [CoefW-1:0] CoefBlue  = 16'd7471;
  localparam int ProdW = ChanW + CoefW;
  localparam int SumW  = ProdW + 2;

  localparam logic [RowWidthW-1:0] RowWidthReset = RowWidthW'(MaxRowPixels);
  localparam logic [ChanW-1:0]     MaxLevelReset = ChanW'(255);

  // red sits in the lowest bits
  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } pixel_t;

  typedef enum logic [1:0] {
    MODE_GRAY   = 2'd0,
    MODE_INVERT = 2'd1,
    MODE_MIRROR = 2'd2,
    MODE_PASS   = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE      = 2'd0,
    CFG_ROW_WIDTH = 2'd1,
    CFG_MAX_LEVEL = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_RD,
    ST_LOAD
  } state_e;

endpackage

/* rtl/pixel_gray_invert_mirror.sv */
// pixel_gray_invert_mirror: top level, stream ports, config registers,
// column counter, row store and read-out sequencer.
// depends on pgim_pkg, pgim_ram, pgim_calc
//
// Usage: RGB pixels enter in raster order on the s_axis channel, one pixel a
// beat. Configuration (mode, row_width, max_level) is written on the cfg
// channel, which is always ready; write it only while the block is idle.
// In grayscale, inversion and pass-through mode each input beat makes one
// output beat on m_axis; the result passes the product register, then the
// output register, and no new pixel is taken until it has been loaded
// into the output register. In mirror mode pixels are written into the row
// store and nothing comes out until the last pixel of a row; then the
// current pixel is sent first and the rest of the row is read back from
// the store through its single registered read port, and no input is
// taken during that read-out. m_axis_tlast marks the last beat of each
// output row.
// Reset clears the column counter, the sequencer and the output valid bit
// and loads the register defaults; the row store is not cleared. A stalled
// receiver holds the output register and the sequencer; one more input beat
// may still be taken while a finished result waits.
module pixel_gray_invert_mirror (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // stream in, tdata: red_in, green_in, blue_in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [pgim_pkg::PixW-1:0]    s_axis_tdata,
  // stream out, tdata: red_out, green_out, blue_out; tlast: row_end
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [pgim_pkg::PixW-1:0]    m_axis_tdata,
  output logic                         m_axis_tlast,
  // register writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pgim_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pgim_pkg::CfgDataW-1:0] cfg_data_i
);
  import pgim_pkg::*;

  mode_e                mode_q;
  logic [RowWidthW-1:0] row_width_q;
  logic [ChanW-1:0]     max_level_q;

  state_e               state_q, state_d;
  logic [ColW-1:0]      cnt_q, cnt_d;
  logic [ColW-1:0]      item_col_q, item_col_d;
  logic                 last_q, last_d;
  logic [ColW-1:0]      rd_idx_q, rd_idx_d;
  logic                 out_valid_q, out_valid_d;
  pixel_t               out_pix_q, out_pix_d;
  logic                 out_last_q, out_last_d;

  logic                 in_beat;
  logic                 out_free;
  logic [RowWidthW-1:0] eff_width;
  logic [RowWidthW-1:0] cnt_plus1;
  logic                 last_now;
  logic                 ram_re;
  logic                 out_load;
  pixel_t               out_sel;
  logic                 out_sel_last;
  pixel_t               in_pix;
  pixel_t               calc_res;
  logic [PixW-1:0]      ram_rdata;

  assign in_pix        = pixel_t'(s_axis_tdata);
  assign in_beat       = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_GRAY;
      row_width_q <= RowWidthReset;
      max_level_q <= MaxLevelReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:      mode_q      <= mode_e'(cfg_data_i[1:0]);
        CFG_ROW_WIDTH: row_width_q <= cfg_data_i[RowWidthW-1:0];
        CFG_MAX_LEVEL: max_level_q <= cfg_data_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // zero width acts as one, oversize widths saturate
  always_comb begin
    if (row_width_q == '0) begin
      eff_width = RowWidthW'(1);
    end else if (row_width_q > RowWidthW'(MaxRowPixels)) begin
      eff_width = RowWidthW'(MaxRowPixels);
    end else begin
      eff_width = row_width_q;
    end
  end

  assign cnt_plus1 = RowWidthW'(cnt_q) + RowWidthW'(1);
  assign last_now  = (cnt_plus1 >= eff_width);

  pgim_ram #(
    .Width (PixW),
    .Depth (MaxRowPixels)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (in_beat),
    .waddr_i (cnt_q),
    .wdata_i (s_axis_tdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  pgim_calc u_calc (
    .clk_i       (clk_i),
    .load_i      (in_beat),
    .pix_i       (in_pix),
    .mode_i      (mode_q),
    .max_level_i (max_level_q),
    .res_o       (calc_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_beat && !(mode_q == MODE_MIRROR && !last_now)) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (out_free) begin
          state_d = (mode_q == MODE_MIRROR && item_col_q != '0) ? ST_RD : ST_IDLE;
        end
      end
      ST_RD: state_d = ST_LOAD;
      ST_LOAD: begin
        if (out_free) begin
          state_d = (rd_idx_q == '0) ? ST_IDLE : ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    out_load      = 1'b0;
    out_sel       = calc_res;
    out_sel_last  = last_q;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_CALC: begin
        out_load = out_free;
        // in mirror the current pixel leads the reversed row
        if (mode_q == MODE_MIRROR) begin
          out_sel_last = (item_col_q == '0);
        end
      end
      ST_RD: ram_re = 1'b1;
      ST_LOAD: begin
        out_load     = out_free;
        out_sel      = pixel_t'(ram_rdata);
        out_sel_last = (rd_idx_q == '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d      = cnt_q;
    item_col_d = item_col_q;
    last_d     = last_q;
    rd_idx_d   = rd_idx_q;
    if (in_beat) begin
      item_col_d = cnt_q;
      last_d     = last_now;
      cnt_d      = last_now ? '0 : cnt_plus1[ColW-1:0];
    end
    if (state_q == ST_CALC && out_free) begin
      rd_idx_d = item_col_q - ColW'(1);
    end else if (state_q == ST_LOAD && out_free) begin
      rd_idx_d = rd_idx_q - ColW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_pix_d   = out_pix_q;
    out_last_d  = out_last_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_pix_d   = out_sel;
      out_last_d  = out_sel_last;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_col_q <= item_col_d;
    last_q     <= last_d;
    rd_idx_q   <= rd_idx_d;
    out_pix_q  <= out_pix_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

  // a mirror beat inside a row produces nothing and keeps taking input
  a_mirror_mid_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && mode_q == MODE_MIRROR && !last_now |=> state_q == ST_IDLE)
    else $error("mirror beat inside a row left idle");

  // every store read is consumed by the load step
  a_read_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RD |=> state_q == ST_LOAD)
    else $error("row store read not followed by load");

  // a row-ending beat restarts the column count
  a_row_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && last_now |=> cnt_q == '0)
    else $error("column count not cleared at row end");

  // no output is loaded while the receiver holds a pending beat
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !out_load)
    else $error("pending output overwritten");

endmodule

/* rtl/pgim_ram.sv */
// pgim_ram: generic single-clock ram, one write and one read port
// read data registered, held while no read is issued
// no dependencies
module pgim_ram #(
  parameter int Width = 48,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pgim_calc.sv */
// pgim_calc: per-pixel datapath, luma products registered at input accept
// sum, inversion and pass-through selected in the following cycle
// depends on pgim_pkg
module pgim_calc (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  pgim_pkg::pixel_t          pix_i,
  input  pgim_pkg::mode_e           mode_i,
  input  logic [pgim_pkg::ChanW-1:0] max_level_i,
  output pgim_pkg::pixel_t          res_o
);
  import pgim_pkg::*;

  logic [ProdW-1:0] prod_r_q, prod_g_q, prod_b_q;
  pixel_t           pix_q;
  logic [SumW-1:0]  luma_sum;
  logic [ChanW-1:0] luma;
  pixel_t           inv;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_r_q <= ProdW'(pix_i.red)   * ProdW'(CoefRed);
      prod_g_q <= ProdW'(pix_i.green) * ProdW'(CoefGreen);
      prod_b_q <= ProdW'(pix_i.blue)  * ProdW'(CoefBlue);
      pix_q    <= pix_i;
    end
  end

  // weights sum below 1.0, so the truncated luma fits a channel
  assign luma_sum = SumW'(prod_r_q) + SumW'(prod_g_q) + SumW'(prod_b_q);
  assign luma     = luma_sum[CoefW +: ChanW];

  always_comb begin
    inv.red   = (pix_q.red   > max_level_i) ? '0 : max_level_i - pix_q.red;
    inv.green = (pix_q.green > max_level_i) ? '0 : max_level_i - pix_q.green;
    inv.blue  = (pix_q.blue  > max_level_i) ? '0 : max_level_i - pix_q.blue;
  end

  always_comb begin
    case (mode_i)
      MODE_GRAY:   res_o = '{blue: luma, green: luma, red: luma};
      MODE_INVERT: res_o = inv;
      default:     res_o = pix_q;
    endcase
  end

endmodule
